// ----- hw/rtl/hws_pkg.sv -----
// shared types, constants and codes for the harmonic waveform synthesiser
// no dependencies; imported by every module of the block
package hws_pkg;

  localparam int DEF_NUM_HARMONICS = 3;
  localparam int DEF_DAC_BITS      = 12;
  localparam int DEF_PERIOD_BITS   = 16;

  localparam int MAX_HARM   = 3;
  localparam int REG_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int MIN_PERIOD = 4;

  // shared multiplier and datapath widths
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 36;
  localparam int MAG_W      = 34;
  localparam int MAG_HALF   = 17;
  localparam int PSCALE_W   = 31;
  localparam int NLO_W      = 48;
  localparam int NUM_W      = 65;
  localparam int DEN_W      = 18;
  localparam int QUOT_W     = 17;
  localparam int ANGLE_W    = 16;
  localparam int DIV_CNT_W  = 5;
  localparam int CODE_W     = 18;

  // sine polynomial, q1.15
  localparam logic [16:0] SIN_C1    = 17'd51472;
  localparam logic [16:0] SIN_C2    = 17'd21024;
  localparam logic [16:0] SIN_C3    = 17'd2320;
  localparam logic [16:0] SIN_MAX   = 17'd32767;
  localparam logic [15:0] QTR_TURN  = 16'd32768;
  localparam logic [16:0] FUND_GAIN = 17'd4096;

  typedef enum logic [2:0] {
    REG_PERIOD, REG_AMP, REG_GAIN2, REG_GAIN3, REG_GAIN4,
    REG_PHASE2, REG_PHASE3, REG_PHASE4
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0]                period;
    logic [REG_W-1:0]                amp;
    logic [MAX_HARM-1:0][REG_W-1:0]  gain;
    logic [MAX_HARM-1:0][REG_W-1:0]  phase;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_DIV, ST_SQ, ST_P1, ST_P2, ST_SIN, ST_GMUL,
    ST_ACC, ST_STEP, ST_SCALE, ST_MLO, ST_MHI, ST_FLOAD, ST_FDIV, ST_WRITE
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_XX, MUL_P1, MUL_P2, MUL_XP, MUL_GS, MUL_AS, MUL_LO, MUL_HI
  } mul_op_t;

  typedef struct packed {
    logic      accept;
    logic      m_init;
    logic      m_step;
    logic      div_fin;
    mul_op_t   mul_op;
    logic      x_load;
    logic      x2_load;
    logic      acc_clr;
    logic      acc_add;
    logic      ps_load;
    logic      nlo_load;
    logic      out_load;
    logic [1:0] hidx;
  } cmd_t;

  typedef struct packed {
    logic n_short;
    logic div_busy;
    logic gain_nz;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/hws_regs.sv -----
// apb register file holding period, amplitude, harmonic gains and phases
// depends on hws_pkg
module hws_regs import hws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t         idx;
  logic             wr;
  logic [REG_W-1:0] rd;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_PERIOD: cfg.period   <= pwdata[REG_W-1:0];
        REG_AMP:    cfg.amp      <= pwdata[REG_W-1:0];
        REG_GAIN2:  cfg.gain[0]  <= pwdata[REG_W-1:0];
        REG_GAIN3:  cfg.gain[1]  <= pwdata[REG_W-1:0];
        REG_GAIN4:  cfg.gain[2]  <= pwdata[REG_W-1:0];
        REG_PHASE2: cfg.phase[0] <= pwdata[REG_W-1:0];
        REG_PHASE3: cfg.phase[1] <= pwdata[REG_W-1:0];
        REG_PHASE4: cfg.phase[2] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: rd = cfg.period;
      REG_AMP:    rd = cfg.amp;
      REG_GAIN2:  rd = cfg.gain[0];
      REG_GAIN3:  rd = cfg.gain[1];
      REG_GAIN4:  rd = cfg.gain[2];
      REG_PHASE2: rd = cfg.phase[0];
      REG_PHASE3: rd = cfg.phase[1];
      REG_PHASE4: rd = cfg.phase[2];
      default:    rd = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-REG_W){1'b0}}, rd};

endmodule

// ----- hw/rtl/hws_ctrl.sv -----
// sequencer: walks the sine terms, the scaling and the final division
// depends on hws_pkg; drives hws_dp through cmd_t and reads status_t
module hws_ctrl import hws_pkg::*; #(
  parameter int NUM_HARMONICS = DEF_NUM_HARMONICS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [1:0] HARM_LIM = 2'(NUM_HARMONICS);

  state_t     state, state_next;
  logic [1:0] hidx, hidx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hidx  <= '0;
    end else begin
      state <= state_next;
      hidx  <= hidx_next;
    end
  end

  always_comb begin
    state_next = state;
    hidx_next  = hidx;
    case (state)
      ST_IDLE:  if (in_valid) state_next = st.n_short ? ST_IDLE : ST_START;
      ST_START: begin
        state_next = ST_DIV;
        hidx_next  = '0;
      end
      ST_DIV:   if (!st.div_busy) state_next = ST_SQ;
      ST_SQ:    state_next = ST_P1;
      ST_P1:    state_next = ST_P2;
      ST_P2:    state_next = ST_SIN;
      ST_SIN:   state_next = ST_GMUL;
      ST_GMUL:  state_next = ST_ACC;
      ST_ACC:   state_next = (hidx < HARM_LIM && st.gain_nz) ? ST_STEP : ST_SCALE;
      ST_STEP: begin
        state_next = ST_DIV;
        hidx_next  = hidx + 2'd1;
      end
      ST_SCALE: state_next = ST_MLO;
      ST_MLO:   state_next = ST_MHI;
      ST_MHI:   state_next = ST_FLOAD;
      ST_FLOAD: state_next = ST_FDIV;
      ST_FDIV:  if (!st.div_busy) state_next = ST_WRITE;
      ST_WRITE: if (st.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    cmd.hidx   = hidx;
    case (state)
      ST_IDLE:  cmd.accept = in_valid;
      ST_START: begin
        cmd.m_init  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_SQ: begin
        cmd.mul_op = MUL_XX;
        cmd.x_load = 1'b1;
      end
      ST_P1: begin
        cmd.mul_op  = MUL_P1;
        cmd.x2_load = 1'b1;
      end
      ST_P2:    cmd.mul_op = MUL_P2;
      ST_SIN:   cmd.mul_op = MUL_XP;
      ST_GMUL:  cmd.mul_op = MUL_GS;
      ST_ACC:   cmd.acc_add = 1'b1;
      ST_STEP:  cmd.m_step = 1'b1;
      ST_SCALE: cmd.mul_op = MUL_AS;
      ST_MLO: begin
        cmd.mul_op  = MUL_LO;
        cmd.ps_load = 1'b1;
      end
      ST_MHI: begin
        cmd.mul_op   = MUL_HI;
        cmd.nlo_load = 1'b1;
      end
      ST_FLOAD: cmd.div_fin = 1'b1;
      ST_WRITE: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ----- hw/rtl/hws_dp.sv -----
// datapath: sample index, serial divider, shared multiplier, sine and sum,
// scaling and the output word register; depends on hws_pkg
module hws_dp import hws_pkg::*; #(
  parameter int DAC_BITS    = DEF_DAC_BITS,
  parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  input  logic                restart,
  output status_t             st,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [DAC_BITS-1:0] dac_code,
  output logic                period_start,
  output logic                clipped
);

  localparam int PB = PERIOD_BITS;
  localparam logic [CODE_W-1:0] MID   = CODE_W'(1) << (DAC_BITS - 1);
  localparam logic [CODE_W-1:0] TOP   = (CODE_W'(1) << DAC_BITS) - CODE_W'(1);
  localparam logic [MUL_B_W-1:0] SCALE = MUL_B_W'((1 << (DAC_BITS - 1)) - 1);
  localparam logic [DIV_CNT_W-1:0] ANG_ITERS = DIV_CNT_W'(ANGLE_W);
  localparam logic [DIV_CNT_W-1:0] FIN_ITERS = DIV_CNT_W'(QUOT_W);

  function automatic logic [REG_W-1:0] gain_at(input cfg_t c, input logic [1:0] i);
    case (i)
      2'd0:    gain_at = c.gain[0];
      2'd1:    gain_at = c.gain[1];
      2'd2:    gain_at = c.gain[2];
      default: gain_at = '0;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] phase_at(input cfg_t c, input logic [1:0] i);
    case (i)
      2'd0:    phase_at = c.phase[0];
      2'd1:    phase_at = c.phase[1];
      2'd2:    phase_at = c.phase[2];
      default: phase_at = '0;
    endcase
  endfunction

  logic [PB-1:0]          n, k, m, m_new;
  logic [PB:0]            m_sum, m_mod;
  logic                   n_short;

  logic [DEN_W-1:0]       rem, dvs;
  logic [QUOT_W-1:0]      sh, quot;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [DEN_W:0]         trial;
  logic                   ge;

  logic [ANGLE_W-1:0]     t, xr, x_c, x, x2;
  logic                   neg;
  logic [16:0]            p1, p2, s_raw;
  logic [15:0]            s_c;
  logic [REG_W-1:0]       phase_sel;
  logic [MUL_A_W-1:0]     gain_sel;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     preg;

  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]       acc_abs;
  logic [MAG_W-1:0]       mag;
  logic [DEN_W-1:0]       den;
  logic [PSCALE_W-1:0]    pscale;
  logic [NLO_W-1:0]       nlo;
  logic [NUM_W-1:0]       num;

  logic [CODE_W-1:0]      off, code_c;
  logic                   clip_c;

  // sample index and harmonic angle index
  assign n       = cfg.period[PB-1:0];
  assign n_short = n < PB'(MIN_PERIOD);
  assign m_sum   = {1'b0, m} + {1'b0, k};
  assign m_mod   = (m_sum >= {1'b0, n}) ? m_sum - {1'b0, n} : m_sum;
  assign m_new   = cmd.m_init ? k : m_mod[PB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.accept) begin
      if (restart || (!n_short && k >= n)) k <= '0;
    end else if (cmd.out_load) begin
      k <= k + PB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.m_init || cmd.m_step) m <= m_new;
  end

  // restoring divider, one quotient bit a cycle
  assign trial = {rem, sh[QUOT_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign num   = {{(NUM_W-NLO_W){1'b0}}, nlo} + {preg[NLO_W-1:0], {MAG_HALF{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.m_init || cmd.m_step) begin
      div_cnt <= ANG_ITERS;
    end else if (cmd.div_fin) begin
      div_cnt <= FIN_ITERS;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.m_init || cmd.m_step) begin
      rem  <= DEN_W'(m_new);
      sh   <= '0;
      quot <= '0;
      dvs  <= DEN_W'(n);
    end else if (cmd.div_fin) begin
      // (num >> 30) split: high part below den, low part shifted in
      rem  <= DEN_W'(num[63:47]);
      sh   <= num[46:30];
      quot <= '0;
      dvs  <= den;
    end else if (div_cnt != '0) begin
      rem  <= ge ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
      sh   <= {sh[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

  // sine of the turn angle
  assign phase_sel = (cmd.hidx == 2'd0) ? '0 : phase_at(cfg, cmd.hidx - 2'd1);
  assign gain_sel  = (cmd.hidx == 2'd0) ? FUND_GAIN
                                        : {1'b0, gain_at(cfg, cmd.hidx - 2'd1)};
  assign t     = quot[ANGLE_W-1:0] + phase_sel;
  assign xr    = {1'b0, t[13:0], 1'b0};
  assign x_c   = t[14] ? QTR_TURN - xr : xr;
  assign p1    = SIN_C2 - preg[31:15];
  assign p2    = SIN_C1 - preg[31:15];
  assign s_raw = preg[31:15];
  assign s_c   = (s_raw > SIN_MAX) ? SIN_MAX[15:0] : s_raw[15:0];

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x   <= x_c;
      neg <= t[15];
    end
    if (cmd.x2_load) x2 <= preg[30:15];
  end

  // shared multiplier, product registered
  assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign mag     = acc_abs[MAG_W-1:0];

  always_comb begin
    case (cmd.mul_op)
      MUL_XX: begin
        mul_a = MUL_A_W'(x_c);
        mul_b = MUL_B_W'(x_c);
      end
      MUL_P1: begin
        mul_a = SIN_C3;
        mul_b = MUL_B_W'(preg[30:15]);
      end
      MUL_P2: begin
        mul_a = p1;
        mul_b = MUL_B_W'(x2);
      end
      MUL_XP: begin
        mul_a = MUL_A_W'(x);
        mul_b = MUL_B_W'(p2);
      end
      MUL_GS: begin
        mul_a = gain_sel;
        mul_b = MUL_B_W'(s_c);
      end
      MUL_AS: begin
        mul_a = MUL_A_W'(cfg.amp);
        mul_b = SCALE;
      end
      MUL_LO: begin
        mul_a = mag[MAG_HALF-1:0];
        mul_b = MUL_B_W'(preg[PSCALE_W-1:0]);
      end
      MUL_HI: begin
        mul_a = mag[MAG_W-1:MAG_HALF];
        mul_b = MUL_B_W'(pscale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    preg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // weighted sum and gain total
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
      den <= '0;
    end else if (cmd.acc_add) begin
      acc <= neg ? acc - $signed(ACC_W'(preg[31:0])) : acc + $signed(ACC_W'(preg[31:0]));
      den <= den + DEN_W'(gain_sel);
    end
    if (cmd.ps_load)  pscale <= preg[PSCALE_W-1:0];
    if (cmd.nlo_load) nlo    <= preg[NLO_W-1:0];
  end

  // centre, saturate
  assign off = CODE_W'(quot);

  always_comb begin
    clip_c = 1'b0;
    if (acc[ACC_W-1]) begin
      if (off > MID) begin
        code_c = '0;
        clip_c = 1'b1;
      end else begin
        code_c = MID - off;
      end
    end else begin
      code_c = MID + off;
      if (code_c > TOP) begin
        code_c = TOP;
        clip_c = 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dac_code     <= code_c[DAC_BITS-1:0];
      period_start <= (k == '0);
      clipped      <= clip_c;
    end
  end

  assign st.n_short  = n_short;
  assign st.div_busy = (div_cnt != '0);
  assign st.gain_nz  = (gain_at(cfg, cmd.hidx) != '0);
  assign st.out_free = !out_valid || !out_stall;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.m_init || cmd.m_step || cmd.div_fin) |-> (div_cnt == '0))
    else $error("divider restarted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output word overwritten");

  a_index_in_period: assert property (@(posedge clk) disable iff (rst)
    cmd.m_init |-> (k < n))
    else $error("sample index outside period");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (dac_code == '0 || dac_code == {DAC_BITS{1'b1}}))
    else $error("clipped code not at a rail");

endmodule

// ----- hw/rtl/harmonic_waveform_synth.sv -----
// top level of the additive harmonic waveform synthesiser
// depends on hws_pkg, hws_regs, hws_ctrl and hws_dp
//
// usage:
//   each word on the input channel (in_valid / in_stall, field restart) is one
//   sample tick. for every tick the block returns one word on the output
//   channel (out_valid / out_stall) carrying dac_code, period_start and
//   clipped, unless the period register is below four, in which case the tick
//   is consumed silently (restart still clears the sample index).
//   registers sit on an apb port at byte address 4*i, always ready, and must be
//   written only while the block is idle; the block does not enforce this.
// throughput:
//   one tick at a time; the next tick is accepted only once the sequencer is
//   idle again. the one-bit-per-cycle divider (an angle division per term and
//   the final scaling division) and the single shared 17x32 multiplier set how
//   long each tick takes.
// reset:
//   synchronous, clears all configuration registers, the sample index and the output valid.
// stalls:
//   the finished word waits in the output register while out_stall is high;
//   the next tick is already accepted and computed, and only the final write
//   of the output register waits for it to be taken.
module harmonic_waveform_synth import hws_pkg::*; #(
  parameter int NUM_HARMONICS = DEF_NUM_HARMONICS,
  parameter int DAC_BITS      = DEF_DAC_BITS,
  parameter int PERIOD_BITS   = DEF_PERIOD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // sample tick channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  restart,
  // converter code channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DAC_BITS-1:0]   dac_code,
  output logic                  period_start,
  output logic                  clipped
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // configuration registers
  hws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one term after another, then scaling and division
  hws_ctrl #(
    .NUM_HARMONICS (NUM_HARMONICS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic, sample index and output register
  hws_dp #(
    .DAC_BITS    (DAC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .restart      (restart),
    .st           (st),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .dac_code     (dac_code),
    .period_start (period_start),
    .clipped      (clipped)
  );

endmodule

// ----- sim/tb_harmonic_waveform_synth.sv -----
// self-checking testbench for the harmonic waveform synthesiser
// depends on hws_pkg and harmonic_waveform_synth; predicts codes with a scoreboard class
`timescale 1ns / 100ps

module tb_harmonic_waveform_synth;
  import hws_pkg::*;

  // expected dac word for one tick
  typedef struct {
    logic [11:0] code;
    logic        pstart;
    logic        clip;
  } dac_word_t;

  // predictor of the synthesiser plus the queue of words still to arrive
  class dac_scoreboard;
    logic [15:0] regs [8];
    logic [15:0] idx;
    dac_word_t   pending [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      idx = '0;
      pending.delete();
      errors = 0;
    endfunction

    function longint sine(logic [15:0] turn);
      longint q, x, x2, p, s;
      q = turn >> 14;
      x = longint'(turn & 16'h3FFF) << 1;
      if (q == 1 || q == 3) x = 32768 - x;
      x2 = (x * x) >> 15;
      p = 21024 - ((2320 * x2) >> 15);
      p = 51472 - ((p * x2) >> 15);
      s = (x * p) >> 15;
      if (s > 32767) s = 32767;
      return (q >= 2) ? -s : s;
    endfunction

    // note an accepted tick and queue the word it will produce
    function void note_tick(logic rs);
      longint n, k, m, x, den, mag, off, code;
      longint unsigned num;
      int used;
      logic clip;
      dac_word_t w;
      n = regs[REG_PERIOD];
      if (rs) idx = '0;
      if (n < MIN_PERIOD) return;
      if (idx >= n) idx = '0;
      k = idx;
      used = 0;
      while (used < 3 && regs[REG_GAIN2 + used] != 0) used++;
      x = sine(16'((k << 16) / n)) * 4096;
      den = 4096;
      for (int j = 0; j < used; j++) begin
        m = (k * (j + 2)) % n;
        x += longint'(regs[REG_GAIN2 + j]) *
             sine(16'((m << 16) / n + regs[REG_PHASE2 + j]));
        den += regs[REG_GAIN2 + j];
      end
      mag = (x < 0) ? -x : x;
      // 2047*amp*mag stays below 2^64 unsigned
      num = longint'(2047 * regs[REG_AMP]) * longint'(mag);
      off = longint'(num / (longint'(den) << 30));
      clip = 1'b0;
      if (x < 0) begin
        if (off > 2048) begin
          code = 0;
          clip = 1'b1;
        end else code = 2048 - off;
      end else begin
        code = 2048 + off;
        if (code > 4095) begin
          code = 4095;
          clip = 1'b1;
        end
      end
      w.code = 12'(code);
      w.pstart = (k == 0);
      w.clip = clip;
      pending.push_back(w);
      idx = 16'(k + 1);
    endfunction

    function void check_word(logic [11:0] code, logic ps, logic cl);
      dac_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word code=%0d", $time, code);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.code !== code || w.pstart !== ps || w.clip !== cl) begin
        $display("%0t: mismatch expected code=%0d start=%0b clip=%0b, got %0d %0b %0b",
                 $time, w.code, w.pstart, w.clip, code, ps, cl);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall, restart = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic [11:0] dac_code;
  logic period_start, clipped;

  dac_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0;   // percent of cycles each side idles
  bit hold_recv = 1'b0;               // long receiver hold-off request
  int quiet = 0;

  always #1 clk = ~clk;

  harmonic_waveform_synth u_dut (.*);

  // input word accepted at this edge: predict before driving the next one
  always @(posedge clk) if (!rst && in_valid && !in_stall) sb.note_tick(restart);

  // output side: check accepted words, then choose next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(dac_code, period_start, clipped);
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t r, logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= APB_ADDR_W'(4 * int'(r)); pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.regs[r] = v;
  endtask

  // offer one tick, optionally preceded by an idle gap
  task automatic send_tick(logic rs);
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
  endtask

  // wait for every queued word, then a margin for a silently consumed tick
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_setup(bit extreme);
    reg_idx_t r;
    for (int i = 0; i < 8; i++) begin
      r = reg_idx_t'(i);
      if (extreme) write_reg(r, ($urandom_range(1)) ? 16'hFFFF : 16'h0000);
      else write_reg(r, 16'($urandom));
    end
    // keep periods mostly small so wraps happen often
    case ($urandom_range(5))
      0: write_reg(REG_PERIOD, 16'($urandom_range(3)));
      1: write_reg(REG_PERIOD, 16'hFFFF);
      default: write_reg(REG_PERIOD, 16'($urandom_range(4, 40)));
    endcase
    if ($urandom_range(2) == 0) write_reg(REG_AMP, 16'h8000);
    else write_reg(REG_AMP, 16'($urandom_range(32768)));
  endtask

  initial begin
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state gives no output, then short periods
    send_tick(1'b0);
    write_reg(REG_PERIOD, 16'd3);
    send_tick(1'b1);
    drain();
    // pure fundamental, full amplitude, with a restart midway
    write_reg(REG_PERIOD, 16'd4);
    write_reg(REG_AMP, 16'h8000);
    for (int i = 0; i < 6; i++) send_tick(i == 3);
    drain();
    // all harmonics on, second at top gain, and odd phases
    write_reg(REG_GAIN2, 16'hFFFF);
    write_reg(REG_GAIN3, 16'h1000);
    write_reg(REG_GAIN4, 16'h0800);
    write_reg(REG_PHASE2, 16'hFFFF);
    write_reg(REG_PHASE3, 16'h4000);
    write_reg(REG_PHASE4, 16'h8000);
    write_reg(REG_PERIOD, 16'd7);
    for (int i = 0; i < 8; i++) send_tick(1'b0);
    drain();
    // gap in the harmonic list, then period changes
    write_reg(REG_GAIN3, 16'h0000);
    write_reg(REG_PERIOD, 16'd5);
    for (int i = 0; i < 4; i++) send_tick(1'b0);
    drain();
    write_reg(REG_PERIOD, 16'd4);
    send_tick(1'b0);
    drain();
    write_reg(REG_PERIOD, 16'hFFFF);
    send_tick(1'b0);
    drain();

    // random phases with different idling mixes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin send_idle = 15; recv_idle = 67; end
      else if (ph < 8) begin send_idle = 67; recv_idle = 15; end
      else begin send_idle = 0; recv_idle = 0; end
      random_setup(ph == 0 || ph == 5);
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering ticks
        fork
          begin
            hold_recv = 1'b1;
            repeat (600) @(posedge clk);
            hold_recv = 1'b0;
          end
          for (int i = 0; i < 10; i++) send_tick(1'(($urandom_range(9)) == 0));
        join
      end
      for (int i = 0; i < 30; i++) send_tick(1'(($urandom_range(15)) == 0));
      drain();
    end

    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/hws_pkg.sv
hw/rtl/hws_regs.sv
hw/rtl/hws_ctrl.sv
hw/rtl/hws_dp.sv
hw/rtl/harmonic_waveform_synth.sv
sim/tb_harmonic_waveform_synth.sv
